[rtl/ray_triangle_hit_test_defines.svh]
// ----------------------------------------------------------------------------
// ray triangle hit test assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_HIT_TEST_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RTH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RTH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RTH_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/rth_pkg.sv]
// ----------------------------------------------------------------------------
// rth_pkg
// shared constants, register map, outcome codes and types
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIR_WIDTH       = 32;

  // register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  // 1.0 in Q2.30
  localparam logic signed [DIR_WIDTH-1:0] DIR_Z_RESET = 32'sh4000_0000;

  // outcome codes
  localparam logic [1:0] OUT_HIT      = 2'd0;
  localparam logic [1:0] OUT_DET_ZERO = 2'd1;
  localparam logic [1:0] OUT_U_RANGE  = 2'd2;
  localparam logic [1:0] OUT_V_RANGE  = 2'd3;

  // pipeline depth
  localparam int MUL_STAGES    = 3;
  localparam int CROSS_STAGES  = MUL_STAGES + 1;
  localparam int DOT_STAGES    = MUL_STAGES + 1;
  localparam int DECIDE_STAGES = 2;
  localparam int PIPE_STAGES   = 1 + CROSS_STAGES + DOT_STAGES + DECIDE_STAGES;

  typedef struct packed {
    logic       hit;
    logic [1:0] outcome;
  } result_t;

endpackage

[rtl/rth_if.sv]
// ----------------------------------------------------------------------------
// rth channel interfaces
// triangle channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rth_tri_if #(
  parameter int COORD_WIDTH = rth_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vert0_x;
  logic signed [COORD_WIDTH-1:0] vert0_y;
  logic signed [COORD_WIDTH-1:0] vert0_z;
  logic signed [COORD_WIDTH-1:0] vert1_x;
  logic signed [COORD_WIDTH-1:0] vert1_y;
  logic signed [COORD_WIDTH-1:0] vert1_z;
  logic signed [COORD_WIDTH-1:0] vert2_x;
  logic signed [COORD_WIDTH-1:0] vert2_y;
  logic signed [COORD_WIDTH-1:0] vert2_z;

  modport source (
    output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z,
    input  ready
  );
  modport sink (
    input  valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z,
    output ready
  );
endinterface

interface rth_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] outcome;

  modport source (output valid, hit, outcome, input ready);
  modport sink (input valid, hit, outcome, output ready);
endinterface

[rtl/rth_mul.sv]
// ----------------------------------------------------------------------------
// rth_mul
// pipelined signed multiplier, four partial products summed over two stages
// ----------------------------------------------------------------------------
module rth_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int NA = 2,
  parameter int NB = 2
) (
  input  logic                            clk,
  input  logic [rth_pkg::MUL_STAGES-1:0]  en,
  input  logic signed [AW-1:0]            a,
  input  logic signed [BW-1:0]            b,
  output logic signed [AW+BW-1:0]         p
);
  import rth_pkg::*;

  localparam int CA = (AW + NA - 1) / NA;
  localparam int CB = (BW + NB - 1) / NB;
  localparam int NP = NA * NB;
  localparam int PW = AW + BW;

  logic signed [NA*CA-1:0] a_ext;
  logic signed [NB*CB-1:0] b_ext;
  logic signed [PW-1:0]    part [NP];
  logic signed [PW-1:0]    pair [NP/2];

  assign a_ext = (NA*CA)'(a);
  assign b_ext = (NB*CB)'(b);

  // low chunks are unsigned, the top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [CA:0]      ca;
      logic signed [CB:0]      cb;
      logic signed [CA+CB+1:0] pp;

      assign ca = (i == NA-1) ? {a_ext[i*CA+CA-1], a_ext[i*CA +: CA]}
                              : {1'b0, a_ext[i*CA +: CA]};
      assign cb = (j == NB-1) ? {b_ext[j*CB+CB-1], b_ext[j*CB +: CB]}
                              : {1'b0, b_ext[j*CB +: CB]};
      assign pp = ca * cb;

      always_ff @(posedge clk) begin
        if (en[0]) begin
          part[i*NB+j] <= PW'(pp) <<< (i*CA + j*CB);
        end
      end
    end
  end

  for (genvar k = 0; k < NP/2; k++) begin : g_pair
    always_ff @(posedge clk) begin
      if (en[1]) begin
        pair[k] <= part[2*k] + part[2*k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p <= pair[0] + pair[1];
    end
  end

endmodule

[rtl/rth_cross.sv]
// ----------------------------------------------------------------------------
// rth_cross
// pipelined cross product of two signed 3-vectors
// ----------------------------------------------------------------------------
module rth_cross #(
  parameter int EW = 33
) (
  input  logic                              clk,
  input  logic [rth_pkg::CROSS_STAGES-1:0]  en,
  input  logic signed [EW-1:0]              a [3],
  input  logic signed [EW-1:0]              b [3],
  output logic signed [2*EW:0]              c [3]
);
  import rth_pkg::*;

  localparam int CW = 2*EW + 1;

  // component k = a[k+1]*b[k+2] - a[k+2]*b[k+1], indices mod 3
  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    logic signed [2*EW-1:0] pa;
    logic signed [2*EW-1:0] pb;

    rth_mul #(.AW(EW), .BW(EW), .NA(2), .NB(2)) u_mul_a (
      .clk (clk),
      .en  (en[MUL_STAGES-1:0]),
      .a   (a[I1]),
      .b   (b[I2]),
      .p   (pa)
    );

    rth_mul #(.AW(EW), .BW(EW), .NA(2), .NB(2)) u_mul_b (
      .clk (clk),
      .en  (en[MUL_STAGES-1:0]),
      .a   (a[I2]),
      .b   (b[I1]),
      .p   (pb)
    );

    always_ff @(posedge clk) begin
      if (en[CROSS_STAGES-1]) begin
        c[k] <= CW'(pa) - CW'(pb);
      end
    end
  end

endmodule

[rtl/rth_dot.sv]
// ----------------------------------------------------------------------------
// rth_dot
// pipelined dot product of the ray direction with a wide 3-vector
// ----------------------------------------------------------------------------
module rth_dot #(
  parameter int CW = 67
) (
  input  logic                                    clk,
  input  logic [rth_pkg::DOT_STAGES-1:0]          en,
  input  logic signed [rth_pkg::DIR_WIDTH-1:0]    dir [3],
  input  logic signed [CW-1:0]                    c [3],
  output logic signed [CW+rth_pkg::DIR_WIDTH+1:0] d
);
  import rth_pkg::*;

  localparam int PW = CW + DIR_WIDTH;
  localparam int DW = PW + 2;

  logic signed [PW-1:0] prod [3];

  for (genvar k = 0; k < 3; k++) begin : g_term
    rth_mul #(.AW(CW), .BW(DIR_WIDTH), .NA(4), .NB(1)) u_mul (
      .clk (clk),
      .en  (en[MUL_STAGES-1:0]),
      .a   (c[k]),
      .b   (dir[k]),
      .p   (prod[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en[DOT_STAGES-1]) begin
      d <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
    end
  end

endmodule

[rtl/rth_decide.sv]
// ----------------------------------------------------------------------------
// rth_decide
// sign adjust against det, then a zero det check and range checks on u, v and u+v
// ----------------------------------------------------------------------------
module rth_decide #(
  parameter int DW = 101
) (
  input  logic                               clk,
  input  logic [rth_pkg::DECIDE_STAGES-1:0]  en,
  input  logic signed [DW-1:0]               det,
  input  logic signed [DW-1:0]               u,
  input  logic signed [DW-1:0]               v,
  output rth_pkg::result_t                   res
);
  import rth_pkg::*;

  logic                 zero;
  logic signed [DW:0]   adet;
  logic signed [DW:0]   au;
  logic signed [DW:0]   av;
  logic signed [DW+1:0] uv;
  logic [1:0]           code;

  // stage 1: flip signs so that det is positive
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero <= (det == '0);
      if (det[DW-1]) begin
        adet <= -(DW+1)'(det);
        au   <= -(DW+1)'(u);
        av   <= -(DW+1)'(v);
      end else begin
        adet <= (DW+1)'(det);
        au   <= (DW+1)'(u);
        av   <= (DW+1)'(v);
      end
    end
  end

  // stage 2: 0 <= u <= det, v >= 0, u+v <= det
  always_comb begin
    uv = (DW+2)'(au) + (DW+2)'(av);
    if (zero) begin
      code = OUT_DET_ZERO;
    end else if (au[DW] || (adet < au)) begin
      code = OUT_U_RANGE;
    end else if (av[DW] || ((DW+2)'(adet) < uv)) begin
      code = OUT_V_RANGE;
    end else begin
      code = OUT_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res.hit     <= (code == OUT_HIT);
      res.outcome <= code;
    end
  end

endmodule

[rtl/ray_triangle_hit_test.sv]
// ----------------------------------------------------------------------------
// ray_triangle_hit_test
// throughput: one triangle per cycle while the result channel is not stalled, 11-stage pipeline
//   (edges, 4 cross product stages, 4 dot product stages, 2 decision stages)
// a stalled result holds the full stages behind it, bubbles among them still fill
// reset: synchronous, clears all valid bits, ray origin to 0, direction to +z
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_test_defines.svh"

module ray_triangle_hit_test #(
  parameter int  COORD_WIDTH = rth_pkg::COORD_WIDTH_DEF,
  localparam int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB    = (DATA_W == 64) ? 3 : 2,
  localparam int ADDR_W      = ADDR_LSB + rth_pkg::REG_IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // triangle and result channels
  rth_tri_if.sink           vertices,
  rth_res_if.source         result
);
  import rth_pkg::*;

  // edge width, cross product width, dot product width
  localparam int EW = COORD_WIDTH + 1;
  localparam int CW = 2*EW + 1;
  localparam int DW = CW + DIR_WIDTH + 2;

  // ray registers
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [DIR_WIDTH-1:0]   dir [3];

  // per-stage valid bits and load enables
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;

  // datapath
  logic signed [COORD_WIDTH-1:0] v0 [3];
  logic signed [COORD_WIDTH-1:0] v1 [3];
  logic signed [COORD_WIDTH-1:0] v2 [3];
  logic signed [EW-1:0]          e1 [3];
  logic signed [EW-1:0]          e2 [3];
  logic signed [EW-1:0]          tv [3];
  logic signed [CW-1:0]          c_det [3];
  logic signed [CW-1:0]          c_u [3];
  logic signed [CW-1:0]          c_v [3];
  logic signed [DW-1:0]          det;
  logic signed [DW-1:0]          num_u;
  logic signed [DW-1:0]          num_v;
  result_t                       res;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // --------------------------------------------------------------------------
  // configuration port, writes complete in the access phase
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:ADDR_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= DIR_Z_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: org[0] <= pwdata[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: org[1] <= pwdata[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: org[2] <= pwdata[COORD_WIDTH-1:0];
        REG_DIR_X:    dir[0] <= pwdata[DIR_WIDTH-1:0];
        REG_DIR_Y:    dir[1] <= pwdata[DIR_WIDTH-1:0];
        REG_DIR_Z:    dir[2] <= pwdata[DIR_WIDTH-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // reads return the sign-extended register
  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X: prdata = DATA_W'(org[0]);
      REG_ORIGIN_Y: prdata = DATA_W'(org[1]);
      REG_ORIGIN_Z: prdata = DATA_W'(org[2]);
      REG_DIR_X:    prdata = DATA_W'(dir[0]);
      REG_DIR_Y:    prdata = DATA_W'(dir[1]);
      REG_DIR_Z:    prdata = DATA_W'(dir[2]);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its successor moves,
  // so bubbles close up behind a stalled result
  // --------------------------------------------------------------------------
  assign en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || result.ready;
  for (genvar k = 0; k < PIPE_STAGES-1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= vertices.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign vertices.ready = en[0];

  // --------------------------------------------------------------------------
  // stage 0: edges e1 = v1 - v0, e2 = v2 - v0 and tvec = origin - v0
  // --------------------------------------------------------------------------
  assign v0[0] = vertices.vert0_x;
  assign v0[1] = vertices.vert0_y;
  assign v0[2] = vertices.vert0_z;
  assign v1[0] = vertices.vert1_x;
  assign v1[1] = vertices.vert1_y;
  assign v1[2] = vertices.vert1_z;
  assign v2[0] = vertices.vert2_x;
  assign v2[1] = vertices.vert2_y;
  assign v2[2] = vertices.vert2_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EW'(v1[k]) - EW'(v0[k]);
        e2[k] <= EW'(v2[k]) - EW'(v0[k]);
        tv[k] <= EW'(org[k]) - EW'(v0[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 1-4: cross products, using the triple product identities
  //   det = (dir x e2) . e1  = dir . (e2 x e1)
  //   u   = tvec . (dir x e2) = dir . (e2 x tvec)
  //   v   = (tvec x e1) . dir = dir . (tvec x e1)
  // so all three share the same dot product unit shape
  // --------------------------------------------------------------------------
  rth_cross #(.EW(EW)) u_cross_det (
    .clk (clk),
    .en  (en[CROSS_STAGES:1]),
    .a   (e2),
    .b   (e1),
    .c   (c_det)
  );

  rth_cross #(.EW(EW)) u_cross_u (
    .clk (clk),
    .en  (en[CROSS_STAGES:1]),
    .a   (e2),
    .b   (tv),
    .c   (c_u)
  );

  rth_cross #(.EW(EW)) u_cross_v (
    .clk (clk),
    .en  (en[CROSS_STAGES:1]),
    .a   (tv),
    .b   (e1),
    .c   (c_v)
  );

  // --------------------------------------------------------------------------
  // stages 5-8: dot products with the ray direction, exact at full width
  // --------------------------------------------------------------------------
  rth_dot #(.CW(CW)) u_dot_det (
    .clk (clk),
    .en  (en[CROSS_STAGES+DOT_STAGES:CROSS_STAGES+1]),
    .dir (dir),
    .c   (c_det),
    .d   (det)
  );

  rth_dot #(.CW(CW)) u_dot_u (
    .clk (clk),
    .en  (en[CROSS_STAGES+DOT_STAGES:CROSS_STAGES+1]),
    .dir (dir),
    .c   (c_u),
    .d   (num_u)
  );

  rth_dot #(.CW(CW)) u_dot_v (
    .clk (clk),
    .en  (en[CROSS_STAGES+DOT_STAGES:CROSS_STAGES+1]),
    .dir (dir),
    .c   (c_v),
    .d   (num_v)
  );

  // --------------------------------------------------------------------------
  // stages 9-10: division-free range checks; the last stage is the output
  // register of the result channel
  // --------------------------------------------------------------------------
  rth_decide #(.DW(DW)) u_decide (
    .clk (clk),
    .en  (en[PIPE_STAGES-1:PIPE_STAGES-DECIDE_STAGES]),
    .det (det),
    .u   (num_u),
    .v   (num_v),
    .res (res)
  );

  assign result.valid   = vld[PIPE_STAGES-1];
  assign result.hit     = res.hit;
  assign result.outcome = res.outcome;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `RTH_ASSERT_IMP(a_hit_code, clk, rst, result.valid, result.hit == (result.outcome == OUT_HIT), "hit flag disagrees with outcome")
  `RTH_ASSERT_NXT(a_accept_fill, clk, rst, vertices.valid && vertices.ready, vld[0], "accepted triangle did not enter the pipeline")
  `RTH_ASSERT_IMP(a_ready_free, clk, rst, !result.valid, vertices.ready, "input blocked while no result is pending")

endmodule

[bench/rth_hit_checker.sv]
// ----------------------------------------------------------------------------
// rth_hit_checker
// follows the ray registers through the register port, predicts the outcome
// of every triangle transaction and compares it against the result channel
// ----------------------------------------------------------------------------
module rth_hit_checker #(
  parameter int COORD_WIDTH = rth_pkg::COORD_WIDTH_DEF,
  parameter int ADDR_W      = 5,
  parameter int DATA_W      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  rth_tri_if                tri_mon,
  rth_res_if                res_mon,
  output int                pending_cnt,
  output int                fail_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_LSB = (DATA_W == 64) ? 3 : 2;

  typedef logic signed [COORD_WIDTH-1:0]        coord_t;
  typedef logic signed [rth_pkg::DIR_WIDTH-1:0] dir_t;
  // headroom for dir * pos * pos sums, kept exact
  typedef logic signed [3*COORD_WIDTH+rth_pkg::DIR_WIDTH+15:0] wide_t;
  typedef coord_t tri_t [9];

  coord_t ray_org [3];
  dir_t   ray_dir [3];

  rth_pkg::result_t expected_hits [$];
  int               mismatches = 0;

  assign fail_cnt = mismatches;

  // crossing test by exact integer comparisons, no division
  function automatic rth_pkg::result_t line_crossing(tri_t vx);
    wide_t v0 [3], v1 [3], v2 [3], dw [3], ow [3];
    wide_t e1 [3], e2 [3], tv [3], pv [3], qv [3];
    wide_t det, uu, vv;
    rth_pkg::result_t r;
    for (int i = 0; i < 3; i++) begin
      v0[i] = vx[i];
      v1[i] = vx[3+i];
      v2[i] = vx[6+i];
      dw[i] = ray_dir[i];
      ow[i] = ray_org[i];
      e1[i] = v1[i] - v0[i];
      e2[i] = v2[i] - v0[i];
      tv[i] = ow[i] - v0[i];
    end
    pv[0] = dw[1] * e2[2] - dw[2] * e2[1];
    pv[1] = dw[2] * e2[0] - dw[0] * e2[2];
    pv[2] = dw[0] * e2[1] - dw[1] * e2[0];
    det = pv[0] * e1[0] + pv[1] * e1[1] + pv[2] * e1[2];
    if (det == 0) begin
      r.outcome = rth_pkg::OUT_DET_ZERO;
    end else begin
      uu = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
      qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
      qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
      qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
      vv = qv[0] * dw[0] + qv[1] * dw[1] + qv[2] * dw[2];
      // fold the sign of det into the numerators
      if (det < 0) begin
        det = -det;
        uu  = -uu;
        vv  = -vv;
      end
      if (uu < 0 || uu > det) r.outcome = rth_pkg::OUT_U_RANGE;
      else if (vv < 0 || uu + vv > det) r.outcome = rth_pkg::OUT_V_RANGE;
      else r.outcome = rth_pkg::OUT_HIT;
    end
    r.hit = (r.outcome == rth_pkg::OUT_HIT);
    return r;
  endfunction

  always @(posedge clk) begin
    tri_t             tri_in;
    rth_pkg::result_t want;
    if (rst) begin
      ray_org = '{default: '0};
      ray_dir = '{dir_t'(0), dir_t'(0), rth_pkg::DIR_Z_RESET};
      expected_hits.delete();
    end else begin
      // triangle first so a transaction sees the ray that was in place
      if (tri_mon.valid && tri_mon.ready) begin
        tri_in = '{tri_mon.vert0_x, tri_mon.vert0_y, tri_mon.vert0_z,
                   tri_mon.vert1_x, tri_mon.vert1_y, tri_mon.vert1_z,
                   tri_mon.vert2_x, tri_mon.vert2_y, tri_mon.vert2_z};
        expected_hits.push_back(line_crossing(tri_in));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, hit %0b outcome %0d", $time,
                   res_mon.hit, res_mon.outcome);
        end else begin
          want = expected_hits.pop_front();
          if (res_mon.hit !== want.hit) begin
            mismatches++;
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, res_mon.hit);
          end
          if (res_mon.outcome !== want.outcome) begin
            mismatches++;
            $display("%0t: outcome expected %0d, got %0d", $time, want.outcome,
                     res_mon.outcome);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:ADDR_LSB])
          rth_pkg::REG_ORIGIN_X: ray_org[0] = pwdata[COORD_WIDTH-1:0];
          rth_pkg::REG_ORIGIN_Y: ray_org[1] = pwdata[COORD_WIDTH-1:0];
          rth_pkg::REG_ORIGIN_Z: ray_org[2] = pwdata[COORD_WIDTH-1:0];
          rth_pkg::REG_DIR_X:    ray_dir[0] = pwdata[rth_pkg::DIR_WIDTH-1:0];
          rth_pkg::REG_DIR_Y:    ray_dir[1] = pwdata[rth_pkg::DIR_WIDTH-1:0];
          rth_pkg::REG_DIR_Z:    ray_dir[2] = pwdata[rth_pkg::DIR_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    pending_cnt = expected_hits.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// ray triangle hit test bench: directed border, degenerate and extreme
// triangles, then phases of random triangles under different rays, mostly
// built around a point on the ray line; both channels idle at random
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW       = rth_pkg::COORD_WIDTH_DEF;
  localparam int DATA_W   = (CW > 32) ? 64 : 32;
  localparam int ADDR_LSB = (DATA_W == 64) ? 3 : 2;
  localparam int ADDR_W   = ADDR_LSB + rth_pkg::REG_IDX_W;

  // cycles with no transaction anywhere before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // receiver hold-off that backs the pipeline up into the input
  localparam int LONG_HOLD   = 250;

  // decoded but unused register slots, writes there must change nothing
  localparam logic [rth_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rth_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [CW-1:0]                 coord_t;
  typedef logic signed [rth_pkg::DIR_WIDTH-1:0] dir_t;
  typedef coord_t tri_t [9];

  localparam coord_t POS_ONE  = coord_t'(1) <<< 16;   // 1.0 in Q16.16
  localparam coord_t POS_HALF = POS_ONE >>> 1;
  localparam coord_t POS_QTR  = POS_ONE >>> 2;
  localparam coord_t C_MAX    = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN    = {1'b1, {(CW-1){1'b0}}};
  localparam dir_t   DIR_ONE  = rth_pkg::DIR_Z_RESET;
  localparam dir_t   DIR_MAX  = 32'sh7fff_ffff;
  localparam dir_t   DIR_MIN  = 32'sh8000_0000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                pending_cnt;
  int                fail_cnt;
  int                quiet = 0;

  // idling controls for the sender and the receiver
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req  = 0;

  // shadow of the ray, used only to aim random triangles at it
  coord_t ray_o [3] = '{default: '0};
  dir_t   ray_d [3] = '{dir_t'(0), dir_t'(0), DIR_ONE};

  rth_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
  rth_res_if                     res_ch ();

  ray_triangle_hit_test #(.COORD_WIDTH(CW)) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .vertices (tri_ch),
    .result   (res_ch)
  );

  rth_hit_checker #(.COORD_WIDTH(CW), .ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .tri_mon     (tri_ch),
    .res_mon     (res_ch),
    .pending_cnt (pending_cnt),
    .fail_cnt    (fail_cnt)
  );

  always #4 clk = ~clk;

  // hang detection: any accepted transaction on any port restarts the count
  always @(posedge clk) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** ray_triangle_hit_test: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // random offset with random sign and a magnitude spread over many octaves
  function automatic coord_t rand_offset();
    return coord_t'($urandom) >>> $urandom_range(CW - 2, CW / 4);
  endfunction

  // unit triangle in the plane z = zc with v0 at (px, py); flip swaps v1 and v2
  // so the determinant changes sign
  function automatic tri_t flat_tri(coord_t px, coord_t py, coord_t zc, bit flip);
    tri_t t;
    t = '{px, py, zc, px + POS_ONE, py, zc, px, py + POS_ONE, zc};
    if (flip) t = '{px, py, zc, px, py + POS_ONE, zc, px + POS_ONE, py, zc};
    return t;
  endfunction

  // random triangle: mostly centered on a point of the current ray line,
  // some with one vertex thrown off, the rest raw random bits
  function automatic tri_t aimed_tri();
    tri_t   t;
    coord_t p [3], w0 [3], w1 [3];
    int     k, r;
    k = int'($urandom_range(128)) - 64;
    r = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      p[i]  = ray_o[i] + coord_t'(ray_d[i] >>> 14) * coord_t'(k);
      w0[i] = rand_offset();
      w1[i] = rand_offset();
      if (r < 60) begin
        // p is the centroid, strictly inside unless the triangle is flat
        t[i] = p[i] + w0[i];
        t[3+i] = p[i] + w1[i];
        t[6+i] = p[i] - w0[i] - w1[i];
      end else if (r < 80) begin
        t[i] = p[i] + w0[i];
        t[3+i] = p[i] + w1[i];
        t[6+i] = p[i] + rand_offset();
      end else begin
        t[i] = coord_t'($urandom);
        t[3+i] = coord_t'($urandom);
        t[6+i] = coord_t'($urandom);
      end
    end
    return t;
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(logic [rth_pkg::REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << ADDR_LSB;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // every triangle yields a result, so an empty expectation store means idle
  task automatic wait_drained();
    do @(negedge clk); while (pending_cnt != 0);
    repeat (rth_pkg::PIPE_STAGES) @(negedge clk);
  endtask

  task automatic set_ray(coord_t ox, coord_t oy, coord_t oz,
                         dir_t dx, dir_t dy, dir_t dz, bit touch_spare);
    wait_drained();
    ray_o = '{ox, oy, oz};
    ray_d = '{dx, dy, dz};
    reg_write(rth_pkg::REG_ORIGIN_X, DATA_W'(ox));
    reg_write(rth_pkg::REG_ORIGIN_Y, DATA_W'(oy));
    reg_write(rth_pkg::REG_ORIGIN_Z, DATA_W'(oz));
    reg_write(rth_pkg::REG_DIR_X, DATA_W'(dx));
    reg_write(rth_pkg::REG_DIR_Y, DATA_W'(dy));
    reg_write(rth_pkg::REG_DIR_Z, DATA_W'(dz));
    if (touch_spare) begin
      reg_write(REG_SPARE_LO, DATA_W'($urandom));
      reg_write(REG_SPARE_HI, DATA_W'($urandom));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one triangle transaction; valid drops only when a gap comes first
  task automatic send_tri(tri_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      tri_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    tri_ch.valid   <= 1'b1;
    tri_ch.vert0_x <= t[0];
    tri_ch.vert0_y <= t[1];
    tri_ch.vert0_z <= t[2];
    tri_ch.vert1_x <= t[3];
    tri_ch.vert1_y <= t[4];
    tri_ch.vert1_z <= t[5];
    tri_ch.vert2_x <= t[6];
    tri_ch.vert2_y <= t[7];
    tri_ch.vert2_z <= t[8];
    do @(posedge clk); while (!tri_ch.ready);
  endtask

  // drop valid right after the last accepted transaction of a phase
  task automatic tri_idle();
    @(negedge clk);
    tri_ch.valid <= 1'b0;
  endtask

  // result side: ready with random stalls, or a long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(3) == 0) begin
        stall_left = ($urandom_range(99) < 85) ? $urandom_range(4, 1)
                                               : $urandom_range(40, 10);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tri_t   t;
    coord_t o [3];
    dir_t   d [3];
    int     n_items;
    int     axis;

    // every input known from time zero
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tri_ch.valid   = 1'b0;
    tri_ch.vert0_x = '0;
    tri_ch.vert0_y = '0;
    tri_ch.vert0_z = '0;
    tri_ch.vert1_x = '0;
    tri_ch.vert1_y = '0;
    tri_ch.vert1_z = '0;
    tri_ch.vert2_x = '0;
    tri_ch.vert2_y = '0;
    tri_ch.vert2_z = '0;

    // hold synchronous reset, then release it
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset ray: origin at 0, direction +z
    // unit triangle moved so the line lands on vertices, edges and just outside
    send_tri(flat_tri('0, '0, POS_ONE, 1'b0));                      // on v0, u = v = 0
    send_tri(flat_tri(-POS_ONE, '0, POS_ONE, 1'b0));                // on v1, u = 1
    send_tri(flat_tri('0, -POS_ONE, POS_ONE, 1'b0));                // on v2, u + v = 1
    send_tri(flat_tri(-POS_HALF, -POS_HALF, POS_ONE, 1'b0));        // on the far edge
    send_tri(flat_tri(-POS_HALF, -POS_HALF, -POS_ONE, 1'b1));       // same, det positive
    send_tri(flat_tri(-POS_QTR, -POS_QTR, POS_ONE, 1'b0));          // interior
    send_tri(flat_tri(-POS_QTR, -POS_QTR, -POS_ONE, 1'b1));         // interior, flipped
    send_tri(flat_tri(POS_QTR, -POS_QTR, POS_ONE, 1'b0));           // u below 0
    send_tri(flat_tri(-POS_ONE - POS_QTR, '0, POS_ONE, 1'b0));      // u above 1
    send_tri(flat_tri(-POS_HALF, POS_QTR, POS_ONE, 1'b0));          // v below 0
    send_tri(flat_tri(-POS_HALF, -POS_HALF - POS_QTR, POS_ONE, 1'b0)); // u + v above 1
    send_tri(flat_tri(-POS_ONE - POS_QTR, '0, POS_ONE, 1'b1));      // flipped, v too big
    // degenerate: single point, collinear, plane parallel to the ray
    send_tri('{POS_ONE, POS_ONE, POS_ONE, POS_ONE, POS_ONE, POS_ONE,
               POS_ONE, POS_ONE, POS_ONE});
    send_tri('{'0, '0, '0, POS_ONE, '0, '0, POS_ONE + POS_ONE, '0, '0});
    send_tri('{POS_ONE, '0, '0, POS_ONE, POS_ONE, '0, POS_ONE, '0, POS_ONE});
    // extreme coordinates
    send_tri('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX});
    send_tri('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN});
    send_tri('{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, '0});
    send_tri('{C_MIN, C_MAX, '0, C_MAX, '0, C_MIN, '0, C_MIN, C_MAX});
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) begin
        case ($urandom_range(3))
          0: t[i] = C_MAX;
          1: t[i] = C_MIN;
          2: t[i] = '0;
          default: t[i] = -1;
        endcase
      end
      send_tri(t);
    end
    tri_idle();

    // random phases, each under its own ray
    for (int ph = 0; ph < 10; ph++) begin
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      n_items   = 95;
      case (ph)
        0: set_ray(C_MAX, C_MIN, C_MAX, -DIR_ONE, '0, '0, 1'b0);
        1: set_ray(C_MIN, C_MAX, C_MIN, '0, DIR_ONE, -DIR_ONE, 1'b1);
        // direction components beyond the unit range, used as given
        2: set_ray('0, '0, '0, DIR_MAX, DIR_MIN, DIR_MAX, 1'b0);
        // zero direction: every triangle reports a zero determinant
        3: begin
          set_ray(rand_offset(), rand_offset(), rand_offset(), '0, '0, '0, 1'b0);
          n_items = 40;
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = rand_offset();
            d[i] = dir_t'($urandom) >>> 1;
          end
          if ($urandom_range(1) == 0) begin
            // axis aligned ray
            axis = $urandom_range(2);
            d = '{default: '0};
            d[axis] = ($urandom_range(1) == 0) ? DIR_ONE : -DIR_ONE;
          end
          set_ray(o[0], o[1], o[2], d[0], d[1], d[2], ph == 7);
        end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while triangles keep coming back to back
        tx_steady = 1'b1;
        hold_req  = LONG_HOLD;
      end
      if (ph == 5) begin
        // no idling on either side
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      for (int n = 0; n < n_items; n++) begin
        // halfway through the pressure phase the sender goes back to gaps
        if (ph == 4 && n == n_items / 2) tx_steady = 1'b0;
        send_tri(aimed_tri());
      end
      tri_idle();
    end

    // let every expected result arrive, then allow a little slack for strays
    do @(negedge clk); while (pending_cnt != 0);
    repeat (rth_pkg::PIPE_STAGES + 4) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("** ray_triangle_hit_test: PASSED **");
    end else begin
      $display("** ray_triangle_hit_test: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rth_pkg.sv
rtl/rth_if.sv
rtl/rth_mul.sv
rtl/rth_cross.sv
rtl/rth_dot.sv
rtl/rth_decide.sv
rtl/ray_triangle_hit_test.sv
bench/rth_hit_checker.sv
bench/tb.sv
